### rtl/core/kpct_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed peer counter table.
// Holds the request and response structs, opcodes and scan states; no dependencies.
package kpct_pkg;

	localparam int unsigned ENTRIES_DEF   = 64;
	localparam int unsigned KEY_WORDS_DEF = 4;
	localparam int unsigned WORD_W        = 64;
	localparam int unsigned REP_W         = 32;
	localparam int unsigned SLOT_W        = 6;
	localparam int unsigned USED_W        = 7;

	typedef enum logic [1:0] {
		OP_GET   = 2'd0,
		OP_APPLY = 2'd1,
		OP_SETREP = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [63:0]       key_word_0;
		logic [63:0]       key_word_1;
		logic [63:0]       key_word_2;
		logic [63:0]       key_word_3;
		logic [63:0]       tx_increment;
		logic [63:0]       rx_increment;
		logic [63:0]       file_increment;
		logic [63:0]       meeting_seen;
		logic signed [31:0] new_rep_score;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [5:0]         slot;
		logic               inserted;
		logic               evicted;
		logic [63:0]        tx_total;
		logic [63:0]        rx_total;
		logic [63:0]        file_total;
		logic [63:0]        last_meeting;
		logic signed [31:0] rep_value;
		logic [6:0]         used_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_READ,
		ST_WRITE,
		ST_OUT
	} state_t;

	// Saturating add of two 64-bit totals.
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

endpackage

### rtl/core/keyed_peer_counter_table.sv
`timescale 1ns / 1ps
// Top level of the keyed peer counter table: scan sequencer, record memories, output register.
// Depends on kpct_pkg.
//
// One request at a time. A get, apply or set-reputation request scans every record in use,
// one record per cycle through the key and meeting memories (registered read), then reads
// the chosen record and, for apply and set-reputation, modifies and writes it back. It
// passes through the drain, read, write and output states, and the next request can be
// taken as soon as the response is valid. Clear goes from scan straight to the output state.
// A response is loaded into the output register only once the previous one has left, so a
// stalled response holds the sequencer in its last state; the next request is taken while
// the new response still waits. No clearing pass after reset.
module keyed_peer_counter_table
	import kpct_pkg::*;
#(
	parameter int unsigned ENTRIES   = ENTRIES_DEF,
	parameter int unsigned KEY_WORDS = KEY_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	input  logic out_ready,
	output logic out_valid,
	output rsp_t out_data
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned KEY_W = 64 * KEY_WORDS;

	// record memories
	logic [KEY_W-1:0] key_mem  [ENTRIES];
	logic [63:0]      tx_mem   [ENTRIES];
	logic [63:0]      rx_mem   [ENTRIES];
	logic [63:0]      file_mem [ENTRIES];
	logic [63:0]      meet_mem [ENTRIES];
	logic [31:0]      rep_mem  [ENTRIES];

	state_t state_q, state_d;
	req_t   req_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_q;        // address being issued
	logic             rd_vld_s1;     // scan read data valid
	logic [IDX_W-1:0] rd_idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic [63:0]      meet_rd_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [63:0]      min_q;
	logic [IDX_W-1:0] min_idx_q;
	logic [IDX_W-1:0] rec_q;
	logic             ins_q, evi_q;
	logic [63:0]      tx_rd, rx_rd, file_rd, meet_rd;
	logic [31:0]      rep_rd;
	logic             out_valid_q;
	rsp_t             out_q;
	rsp_t             rsp_d;
	logic [KEY_W-1:0] req_key;

	logic [255:0] key_all;
	assign key_all = {req_q.key_word_3, req_q.key_word_2, req_q.key_word_1, req_q.key_word_0};
	assign req_key = key_all[KEY_W-1:0];

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic accept, scan_go, match;
	assign accept  = in_valid && in_ready;
	assign scan_go = (state_q == ST_SCAN) && (scan_q < fill_q);
	assign match   = rd_vld_s1 && !hit_q && (key_rd_s1 == req_key);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SCAN;
			ST_SCAN: begin
				if (op_t'(req_q.opcode) == OP_CLEAR) begin
					state_d = ST_OUT;
				end else if (!scan_go) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_READ;
			ST_READ:  state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan: issue reads, compare and track minimum in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			scan_q    <= '0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_go;
			if (accept) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
			end else if (scan_go) begin
				scan_q <= scan_q + 1'b1;
			end
			if (match) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= in_data;
		if (scan_go) begin
			rd_idx_s1  <= scan_q[IDX_W-1:0];
			key_rd_s1  <= key_mem[scan_q[IDX_W-1:0]];
			meet_rd_s1 <= meet_mem[scan_q[IDX_W-1:0]];
		end
		if (match) hit_idx_q <= rd_idx_s1;
		if (rd_vld_s1 && (rd_idx_s1 == '0 || meet_rd_s1 < min_q)) begin
			min_q     <= meet_rd_s1;
			min_idx_q <= rd_idx_s1;
		end
	end

	// choose record at drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (state_q == ST_SCAN && op_t'(req_q.opcode) == OP_CLEAR) begin
			fill_q <= '0;
		end else if (state_q == ST_DRAIN && !hit_q && op_t'(req_q.opcode) != OP_GET
				&& fill_q < CNT_W'(ENTRIES)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			ins_q <= !hit_q && op_t'(req_q.opcode) != OP_GET;
			evi_q <= !hit_q && op_t'(req_q.opcode) != OP_GET && fill_q >= CNT_W'(ENTRIES);
			if (hit_q) rec_q <= hit_idx_q;
			else if (fill_q < CNT_W'(ENTRIES)) rec_q <= fill_q[IDX_W-1:0];
			else rec_q <= min_idx_q;
		end
		if (state_q == ST_READ) begin
			tx_rd   <= tx_mem[rec_q];
			rx_rd   <= rx_mem[rec_q];
			file_rd <= file_mem[rec_q];
			meet_rd <= meet_mem[rec_q];
			rep_rd  <= rep_mem[rec_q];
		end
	end

	// modify the chosen record
	logic [63:0] tx_n, rx_n, file_n, meet_n, tx_b, rx_b, file_b, meet_b;
	logic [31:0] rep_n, rep_b;
	logic        do_wr;
	always_comb begin
		tx_b   = ins_q ? '0 : tx_rd;
		rx_b   = ins_q ? '0 : rx_rd;
		file_b = ins_q ? '0 : file_rd;
		meet_b = ins_q ? '0 : meet_rd;
		rep_b  = ins_q ? '0 : rep_rd;
		tx_n = tx_b; rx_n = rx_b; file_n = file_b; meet_n = meet_b; rep_n = rep_b;
		if (op_t'(req_q.opcode) == OP_APPLY) begin
			tx_n   = sat_add(tx_b, req_q.tx_increment);
			rx_n   = sat_add(rx_b, req_q.rx_increment);
			file_n = sat_add(file_b, req_q.file_increment);
			if (req_q.meeting_seen > meet_b) meet_n = req_q.meeting_seen;
		end else if (op_t'(req_q.opcode) == OP_SETREP) begin
			rep_n = req_q.new_rep_score;
		end
		do_wr = (state_q == ST_WRITE) && op_t'(req_q.opcode) != OP_GET;
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			tx_mem[rec_q]   <= tx_n;
			rx_mem[rec_q]   <= rx_n;
			file_mem[rec_q] <= file_n;
			meet_mem[rec_q] <= meet_n;
			rep_mem[rec_q]  <= rep_n;
			if (ins_q) key_mem[rec_q] <= req_key;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && state_d == ST_IDLE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [63:0] rec_slot;
	assign rec_slot = 64'(rec_q);

	// build the response; the modified values hold until the next request is taken
	always_comb begin
		rsp_d = '0;
		if (op_t'(req_q.opcode) != OP_CLEAR) begin
			rsp_d.used_count = USED_W'(fill_q);
			if (op_t'(req_q.opcode) != OP_GET || hit_q) begin
				rsp_d.found        = hit_q;
				rsp_d.slot         = rec_slot[SLOT_W-1:0];
				rsp_d.inserted     = ins_q;
				rsp_d.evicted      = evi_q;
				rsp_d.tx_total     = tx_n;
				rsp_d.rx_total     = rx_n;
				rsp_d.file_total   = file_n;
				rsp_d.last_meeting = meet_n;
				rsp_d.rep_value    = rep_n;
			end
		end
	end

	// load the response only when the output register is free
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && state_d == ST_IDLE) out_q <= rsp_d;
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES)) else $error("fill above capacity");
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && evi_q) |-> (fill_q == CNT_W'(ENTRIES)))
		else $error("eviction with free space");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_ins_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> !(ins_q && hit_q)) else $error("insert on hit");

endmodule
